>>> src/humidity_temp_frame_decoder_defines.svh
// assertion macros shared by the frame decoder rtl
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define HTFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HTFD_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HTFD_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

>>> src/htfd_pkg.sv
// types, constants and crc function for the humidity/temperature frame decoder
package htfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  STATUS_MASK = 8'h88;
    localparam logic [7:0]  STATUS_OK   = 8'h08;
    localparam logic [2:0]  LAST_INDEX  = 3'd6;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [14:0] TEMP_OFFSET = 15'd5000;
    localparam int          RAW_W       = 20;
    localparam int          TDATA_OUT_W = 72;

    typedef enum logic [1:0] {
        FS_OK         = 2'd0,
        FS_STATUS_ERR = 2'd1,
        FS_CRC_ERR    = 2'd2
    } t_frame_status;

    // first member sits highest, so frame_status lands in the low bits
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [RAW_W-1:0]   temperature_raw;
        logic [RAW_W-1:0]   humidity_raw;
        t_frame_status      frame_status;
    } t_result;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/humidity_temp_frame_decoder.sv
// top level: sensor readout frame decoder with crc check and fixed-point scaling
//
// input stream: one sensor byte per word on s_axis_tdata, s_axis_tuser high marks
// the status byte that opens a frame. a frame is status, five data bytes, crc byte.
// a byte without the flag while no frame is open is also taken as status, and a
// flagged byte in mid-frame restarts the frame.
// output stream: one word per completed frame carrying the frame status (ok,
// bad status bits, crc mismatch), the two 20-bit raw codes, humidity in 0.01 %
// and temperature in 0.01 C. on any error all data fields are zero.
// throughput: one byte per cycle while s_axis_tready is high. bytes update the
// byte counter, running crc and data shift register; the result word is built from
// those registers (20-bit by 14-bit and 20-bit by 15-bit multiplies) and registered
// when the crc byte is accepted.
// stall: results land in an output register backed by a one-word skid register,
// so bytes keep flowing while the receiver stalls; s_axis_tready drops only while
// the skid register is full, which needs two frames pending.
// reset (i_rst_n low, synchronous): counter cleared, crc set to 0xff, both
// output registers emptied.
module humidity_temp_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [htfd_pkg::TDATA_OUT_W-1:0] m_axis_tdata
    // m_axis_tdata: [1:0] frame_status, [21:2] humidity_raw, [41:22] temperature_raw,
    // [55:42] humidity_centi, [70:56] temperature_centi, [71] zero
);

    import htfd_pkg::*;

    `include "humidity_temp_frame_decoder_defines.svh"

    // frame state
    logic [2:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_status, n_status;
    logic [39:0] r_shift, n_shift;

    // output register and skid
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    in_accept;
    logic    is_start;
    logic    is_last;
    logic    res_valid;
    t_result res;

    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] temp_raw;
    logic [33:0]      hum_prod;
    logic [34:0]      temp_prod;
    logic [14:0]      temp_scaled;

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_start      = s_axis_tuser || (r_byte_count == 3'd0);
    assign is_last       = !is_start && (r_byte_count == LAST_INDEX);
    assign res_valid     = in_accept && is_last;

    // frame state update
    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_status     = r_status;
        n_shift      = r_shift;
        if (in_accept) begin
            priority if (is_start) begin
                n_status     = s_axis_tdata;
                n_crc        = crc8_byte(CRC_INIT, s_axis_tdata);
                n_shift      = '0;
                n_byte_count = 3'd1;
            end else if (!is_last) begin
                n_crc        = crc8_byte(r_crc, s_axis_tdata);
                n_shift      = {r_shift[31:0], s_axis_tdata};
                n_byte_count = r_byte_count + 3'd1;
            end else begin
                n_crc        = CRC_INIT;
                n_byte_count = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 3'd0;
            r_crc        <= CRC_INIT;
            r_status     <= 8'd0;
            r_shift      <= 40'd0;
        end else begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_status     <= n_status;
            r_shift      <= n_shift;
        end
    end

    // result word, valid when the crc byte comes in
    assign hum_raw     = r_shift[39:20];
    assign temp_raw    = r_shift[19:0];
    assign hum_prod    = 34'(hum_raw) * 34'(HUM_SCALE);
    assign temp_prod   = 35'(temp_raw) * 35'(TEMP_SCALE);
    assign temp_scaled = temp_prod[34:20];

    always_comb begin
        res = '0;
        priority if ((r_status & STATUS_MASK) != STATUS_OK) begin
            res.frame_status = FS_STATUS_ERR;
        end else if (r_crc != s_axis_tdata) begin
            res.frame_status = FS_CRC_ERR;
        end else begin
            res.frame_status      = FS_OK;
            res.humidity_raw      = hum_raw;
            res.temperature_raw   = temp_raw;
            res.humidity_centi    = hum_prod[33:20];
            res.temperature_centi = signed'(temp_scaled - TEMP_OFFSET);
        end
    end

    // output register with skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || m_axis_tready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // checks
    `HTFD_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid full while output empty")
    `HTFD_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready), "skid filled without a stall")
    `HTFD_ASSERT(a_count_range, i_clk, i_rst_n, r_byte_count <= LAST_INDEX, "byte counter past frame end")
    `HTFD_ASSERT(a_err_zero_fields, i_clk, i_rst_n, (r_out_valid && r_out.frame_status != FS_OK) |-> (r_out.humidity_raw == '0 && r_out.temperature_raw == '0 && r_out.humidity_centi == '0 && r_out.temperature_centi == '0), "failed frame carries data")
    `HTFD_ASSERT_NORST(a_reset_clears, i_clk, !i_rst_n |=> (!r_out_valid && !r_skid_valid && r_byte_count == 3'd0), "reset did not clear control state")

endmodule
